### rtl/ctsp_pkg.sv
// shared types, constants and elaboration-time functions of the constant turn predictor
package ctsp_pkg;

    localparam int ROTATE_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int GUARD_BITS        = 8;

    localparam int DATA_W = 32;
    localparam int DT_W   = 16;
    localparam int TURN_W = 24;
    localparam int XW     = 42;
    localparam int ANG_W  = 41;
    localparam int RED_W  = 41;
    localparam int RED_STAGES    = 3;
    localparam int RED_PER_STAGE = 3;
    localparam int RX_W   = XW - GUARD_BITS;
    localparam int DV_W   = 36;
    localparam int DIV_DW = DV_W + 16;
    localparam int DIV_SW = 24;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = DIV_DW / DIV_BITS;
    localparam int DIV_LAT    = DIV_STAGES + 2;
    localparam int Q_W        = DIV_DW + 1;
    localparam int IN_W  = 144;
    localparam int OUT_W = 128;

    localparam longint PI_Q28      = 843314857;
    localparam longint HALF_PI_Q28 = 421657428;
    localparam longint TWO_PI_Q28  = 1686629713;

    localparam logic signed [TURN_W-1:0] TURN_RESET = 24'sd6554;

    typedef struct packed {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic signed [DATA_W-1:0] lin_px;
        logic signed [DATA_W-1:0] lin_py;
        logic                     straight;
    } side_t;

    function automatic longint atan_q30(input int i);
        longint a;
        case (i)
            0:  a = 843314856;
            1:  a = 497837829;
            2:  a = 263043836;
            3:  a = 133525158;
            4:  a = 67021686;
            5:  a = 33543515;
            6:  a = 16775850;
            7:  a = 8388437;
            8:  a = 4194282;
            9:  a = 2097149;
            10: a = 1048575;
            11: a = 524287;
            12: a = 262143;
            13: a = 131071;
            14: a = 65535;
            15: a = 32767;
            16: a = 16383;
            17: a = 8191;
            18: a = 4095;
            19: a = 2047;
            20: a = 1023;
            21: a = 511;
            22: a = 255;
            23: a = 127;
            24: a = 63;
            25: a = 31;
            26: a = 15;
            27: a = 7;
            28: a = 3;
            29: a = 1;
            default: a = 0;
        endcase
        return a;
    endfunction

    // stage angle rounded half up from q30 to the rotator's fraction width
    function automatic longint atan_stage(input int i, input int frac);
        int sh;
        sh = 30 - frac;
        return (atan_q30(i) + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    // inverse rotator gain in q30, 2^60 / isqrt(prod(1 + 2^-2i) in q60)
    function automatic logic [63:0] inv_gain_q30(input int n);
        logic [63:0] p;
        logic [63:0] nn;
        logic [63:0] res;
        logic [63:0] bv;
        logic [64:0] r;
        logic [63:0] q;
        p = 64'd1 << 60;
        for (int i = 0; i < 32; i++) begin
            if (i < n) begin
                p = p + (p >> (2 * i));
            end
        end
        nn  = p;
        res = '0;
        bv  = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bv > nn) begin
                bv = bv >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (bv != 0) begin
                if (nn >= res + bv) begin
                    nn  = nn - (res + bv);
                    res = (res >> 1) + bv;
                end else begin
                    res = res >> 1;
                end
                bv = bv >> 2;
            end
        end
        r = '0;
        q = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[63:0], (k == 60) ? 1'b1 : 1'b0};
            if (r >= {1'b0, res}) begin
                r    = r - {1'b0, res};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] s;
        if (v > 64'sd2147483647) begin
            s = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            s = 32'sh80000000;
        end else begin
            s = v[DATA_W-1:0];
        end
        return s;
    endfunction

endpackage

### rtl/ctsp_front.sv
// front end: gain and line products, angle reduction, quarter swap and angle rounding
module ctsp_front #(
    parameter int ROTATE_STAGES = ctsp_pkg::ROTATE_STAGES_DEF,
    parameter int FRAC_BITS     = ctsp_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [ctsp_pkg::DATA_W-1:0]   in_px,
    input  logic signed [ctsp_pkg::DATA_W-1:0]   in_py,
    input  logic signed [ctsp_pkg::DATA_W-1:0]   in_vx,
    input  logic signed [ctsp_pkg::DATA_W-1:0]   in_vy,
    input  logic        [ctsp_pkg::DT_W-1:0]     in_dt,
    input  logic signed [ctsp_pkg::TURN_W-1:0]   yaw_rate,
    output logic                                 out_valid,
    output logic signed [ctsp_pkg::XW-1:0]       out_x,
    output logic signed [ctsp_pkg::XW-1:0]       out_y,
    output logic signed [FRAC_BITS+3:0]          out_z,
    output ctsp_pkg::side_t                      out_side
);
    import ctsp_pkg::*;

    localparam int ZW = FRAC_BITS + 4;
    localparam int SH = 28 - FRAC_BITS;
    localparam logic [63:0] GAIN64 = inv_gain_q30(ROTATE_STAGES);
    localparam logic signed [DATA_W-1:0] GAIN = $signed(GAIN64[DATA_W-1:0]);
    localparam int GSH = 30 - GUARD_BITS;

    // stage a: products
    logic                    a_valid_reg;
    side_t                   a_side_reg;
    logic signed [63:0]      a_gx_reg, a_gy_reg;
    logic signed [48:0]      a_lx_reg, a_ly_reg;
    logic signed [ANG_W-1:0] a_ang_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg.px       <= in_px;
            a_side_reg.py       <= in_py;
            a_side_reg.vx       <= in_vx;
            a_side_reg.vy       <= in_vy;
            a_side_reg.lin_px   <= '0;
            a_side_reg.lin_py   <= '0;
            a_side_reg.straight <= (yaw_rate == '0);
            a_gx_reg  <= in_vx * GAIN;
            a_gy_reg  <= in_vy * GAIN;
            a_lx_reg  <= in_vx * $signed({1'b0, in_dt});
            a_ly_reg  <= in_vy * $signed({1'b0, in_dt});
            a_ang_reg <= yaw_rate * $signed({1'b0, in_dt});
        end
    end

    // reduction stages: magnitude modulo two pi, three quotient bits per stage
    logic                    r_valid_reg [RED_STAGES];
    side_t                   r_side_reg  [RED_STAGES];
    logic signed [XW-1:0]    r_x_reg     [RED_STAGES];
    logic signed [XW-1:0]    r_y_reg     [RED_STAGES];
    logic [RED_W-1:0]        r_mag_reg   [RED_STAGES];
    logic                    r_neg_reg   [RED_STAGES];

    for (genvar k = 0; k < RED_STAGES; k++) begin : g_red
        logic              vi;
        side_t             si;
        logic signed [XW-1:0] xi, yi;
        logic [RED_W-1:0]  mi;
        logic              ni;
        logic [RED_W-1:0]  mag_next;

        if (k == 0) begin : g_first
            logic signed [63:0] gxr, gyr;
            assign gxr = a_gx_reg + (64'sd1 <<< (GSH - 1));
            assign gyr = a_gy_reg + (64'sd1 <<< (GSH - 1));
            assign vi = a_valid_reg;
            always_comb begin
                si        = a_side_reg;
                si.lin_px = sat32(64'(a_side_reg.px) + ((64'(a_lx_reg) + 64'sd2048) >>> 12));
                si.lin_py = sat32(64'(a_side_reg.py) + ((64'(a_ly_reg) + 64'sd2048) >>> 12));
            end
            assign xi = XW'(gxr >>> GSH);
            assign yi = XW'(gyr >>> GSH);
            assign ni = a_ang_reg[ANG_W-1];
            assign mi = ni ? RED_W'(-a_ang_reg) : RED_W'(a_ang_reg);
        end else begin : g_rest
            assign vi = r_valid_reg[k-1];
            assign si = r_side_reg[k-1];
            assign xi = r_x_reg[k-1];
            assign yi = r_y_reg[k-1];
            assign mi = r_mag_reg[k-1];
            assign ni = r_neg_reg[k-1];
        end

        always_comb begin
            logic [RED_W-1:0] lim;
            mag_next = mi;
            for (int j = 0; j < RED_PER_STAGE; j++) begin
                lim = RED_W'(TWO_PI_Q28) << (RED_STAGES * RED_PER_STAGE - 1
                                              - k * RED_PER_STAGE - j);
                if (mag_next >= lim) begin
                    mag_next = mag_next - lim;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                r_valid_reg[k] <= 1'b0;
            end else if (en) begin
                r_valid_reg[k] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_side_reg[k] <= si;
                r_x_reg[k]    <= xi;
                r_y_reg[k]    <= yi;
                r_mag_reg[k]  <= mag_next;
                r_neg_reg[k]  <= ni;
            end
        end
    end

    // normalize stage: signed remainder into (-pi, pi]
    logic                 n_valid_reg;
    side_t                n_side_reg;
    logic signed [XW-1:0] n_x_reg, n_y_reg;
    logic signed [32:0]   n_r_reg;
    logic signed [32:0]   n_r_next;

    always_comb begin
        n_r_next = $signed({2'b00, r_mag_reg[RED_STAGES-1][30:0]});
        if (r_neg_reg[RED_STAGES-1]) begin
            n_r_next = -n_r_next;
        end
        if (n_r_next < 0) begin
            n_r_next = n_r_next + 33'(TWO_PI_Q28);
        end
        if (n_r_next > 33'(PI_Q28)) begin
            n_r_next = n_r_next - 33'(TWO_PI_Q28);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_valid_reg <= 1'b0;
        end else if (en) begin
            n_valid_reg <= r_valid_reg[RED_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_side_reg <= r_side_reg[RED_STAGES-1];
            n_x_reg    <= r_x_reg[RED_STAGES-1];
            n_y_reg    <= r_y_reg[RED_STAGES-1];
            n_r_reg    <= n_r_next;
        end
    end

    // swap stage: take out a quarter turn exactly, round the residual angle
    logic                 s_valid_reg;
    side_t                s_side_reg;
    logic signed [XW-1:0] s_x_reg, s_y_reg, s_x_next, s_y_next;
    logic signed [ZW-1:0] s_z_reg, s_z_next;

    always_comb begin
        logic signed [32:0] r;
        r        = n_r_reg;
        s_x_next = n_x_reg;
        s_y_next = n_y_reg;
        if (r > 33'(HALF_PI_Q28)) begin
            s_x_next = -n_y_reg;
            s_y_next = n_x_reg;
            r        = r - 33'(HALF_PI_Q28);
        end else if (r < -33'(HALF_PI_Q28)) begin
            s_x_next = n_y_reg;
            s_y_next = -n_x_reg;
            r        = r + 33'(HALF_PI_Q28);
        end
        s_z_next = ZW'((r + 33'(longint'(1) << (SH - 1))) >>> SH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_valid_reg <= 1'b0;
        end else if (en) begin
            s_valid_reg <= n_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_side_reg <= n_side_reg;
            s_x_reg    <= s_x_next;
            s_y_reg    <= s_y_next;
            s_z_reg    <= s_z_next;
        end
    end

    assign out_valid = s_valid_reg;
    assign out_x     = s_x_reg;
    assign out_y     = s_y_reg;
    assign out_z     = s_z_reg;
    assign out_side  = s_side_reg;

endmodule

### rtl/ctsp_cordic.sv
// pipelined cordic rotator, one micro-rotation per stage
module ctsp_cordic #(
    parameter int ROTATE_STAGES = ctsp_pkg::ROTATE_STAGES_DEF,
    parameter int FRAC_BITS     = ctsp_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [ctsp_pkg::XW-1:0] in_x,
    input  logic signed [ctsp_pkg::XW-1:0] in_y,
    input  logic signed [FRAC_BITS+3:0]    in_z,
    input  ctsp_pkg::side_t                in_side,
    output logic                           out_valid,
    output logic signed [ctsp_pkg::XW-1:0] out_x,
    output logic signed [ctsp_pkg::XW-1:0] out_y,
    output ctsp_pkg::side_t                out_side
);
    import ctsp_pkg::*;

    localparam int ZW = FRAC_BITS + 4;

    logic                 valid_reg [ROTATE_STAGES];
    side_t                side_reg  [ROTATE_STAGES];
    logic signed [XW-1:0] x_reg     [ROTATE_STAGES];
    logic signed [XW-1:0] y_reg     [ROTATE_STAGES];
    logic signed [ZW-1:0] z_reg     [ROTATE_STAGES];

    for (genvar i = 0; i < ROTATE_STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ANG = ZW'(atan_stage(i, FRAC_BITS));
        logic                 vi;
        side_t                si;
        logic signed [XW-1:0] xi, yi, xs, ys, x_next, y_next;
        logic signed [ZW-1:0] zi, z_next;

        if (i == 0) begin : g_first
            assign vi = in_valid;
            assign si = in_side;
            assign xi = in_x;
            assign yi = in_y;
            assign zi = in_z;
        end else begin : g_rest
            assign vi = valid_reg[i-1];
            assign si = side_reg[i-1];
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end

        assign xs = xi >>> i;
        assign ys = yi >>> i;

        // zero residual angle turns the positive way
        always_comb begin
            if (zi >= 0) begin
                x_next = xi - ys;
                y_next = yi + xs;
                z_next = zi - ANG;
            end else begin
                x_next = xi + ys;
                y_next = yi - xs;
                z_next = zi + ANG;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i] <= si;
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
            end
        end
    end

    assign out_valid = valid_reg[ROTATE_STAGES-1];
    assign out_x     = x_reg[ROTATE_STAGES-1];
    assign out_y     = y_reg[ROTATE_STAGES-1];
    assign out_side  = side_reg[ROTATE_STAGES-1];

endmodule

### rtl/ctsp_div.sv
// pipelined signed divider, velocity change times 2^16 over turn rate, truncating
module ctsp_div (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [ctsp_pkg::DV_W-1:0]   num,
    input  logic signed [ctsp_pkg::TURN_W-1:0] den,
    output logic signed [ctsp_pkg::Q_W-1:0]    quo
);
    import ctsp_pkg::*;

    logic              neg0_reg;
    logic [DIV_DW-1:0] dd0_reg;
    logic [DIV_SW-1:0] dsr0_reg;
    logic [DV_W-2:0]   num_mag;

    assign num_mag = num[DV_W-1] ? (DV_W-1)'(-num) : num[DV_W-2:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            neg0_reg <= num[DV_W-1] ^ den[TURN_W-1];
            dd0_reg  <= {1'b0, num_mag, 16'd0};
            dsr0_reg <= den[TURN_W-1] ? DIV_SW'(-den) : DIV_SW'(den);
        end
    end

    logic [DIV_SW:0]   rem_reg [DIV_STAGES];
    logic [DIV_DW-1:0] dd_reg  [DIV_STAGES];
    logic [DIV_SW-1:0] dsr_reg [DIV_STAGES];
    logic              neg_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DIV_SW:0]   ri, rem_next;
        logic [DIV_DW-1:0] di, dd_next;
        logic [DIV_SW-1:0] si;
        logic              ni;

        if (k == 0) begin : g_first
            assign ri = '0;
            assign di = dd0_reg;
            assign si = dsr0_reg;
            assign ni = neg0_reg;
        end else begin : g_rest
            assign ri = rem_reg[k-1];
            assign di = dd_reg[k-1];
            assign si = dsr_reg[k-1];
            assign ni = neg_reg[k-1];
        end

        // restoring steps, quotient bits shift in at the bottom of the dividend
        always_comb begin
            rem_next = ri;
            dd_next  = di;
            for (int j = 0; j < DIV_BITS; j++) begin
                rem_next = {rem_next[DIV_SW-1:0], dd_next[DIV_DW-1]};
                dd_next  = {dd_next[DIV_DW-2:0], 1'b0};
                if (rem_next >= {1'b0, si}) begin
                    rem_next   = rem_next - {1'b0, si};
                    dd_next[0] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                dd_reg[k]  <= dd_next;
                dsr_reg[k] <= si;
                neg_reg[k] <= ni;
            end
        end
    end

    logic signed [Q_W-1:0] quo_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= neg_reg[DIV_STAGES-1] ? -$signed({1'b0, dd_reg[DIV_STAGES-1]})
                                             : $signed({1'b0, dd_reg[DIV_STAGES-1]});
        end
    end

    assign quo = quo_reg;

endmodule

### rtl/constant_turn_state_predict_unit.sv
// top level of the constant turn rate state predictor
//
// Streams 2D target states through a constant turn rate motion model.
// Input words on s_t* carry position, velocity and time step; output
// words on m_t* carry the predicted position and velocity, one per input.
// The turn rate register is written over cfg_valid/cfg_ready/cfg_data,
// which is always ready; write it only while no word is in flight.
// A turn rate of zero gives straight-line motion.
// Throughput: one word per cycle while the output does not stall. Words
// pass through the six front stages, one cordic stage per micro-rotation,
// a rounding stage, the fifteen-stage divider and the output register.
// All stages advance together; when m_tready is low with a word waiting,
// the whole pipeline holds and s_tready drops, so nothing is lost or
// repeated. Reset empties the pipeline and loads the turn rate with 6554
// (about 0.1 rad/s).
module constant_turn_state_predict_unit #(
    parameter int ROTATE_STAGES = ctsp_pkg::ROTATE_STAGES_DEF,
    parameter int FRAC_BITS     = ctsp_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x, pos_y, vel_x, vel_y, step_time
    input  logic [ctsp_pkg::IN_W-1:0]          s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // next_pos_x, next_pos_y, next_vel_x, next_vel_y
    output logic [ctsp_pkg::OUT_W-1:0]         m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic signed [ctsp_pkg::TURN_W-1:0] cfg_data
);
    import ctsp_pkg::*;

    logic                     en;
    logic signed [TURN_W-1:0] yaw_rate_reg;
    logic                     m_tvalid_reg;
    logic [OUT_W-1:0]         m_tdata_reg;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_rate_reg <= TURN_RESET;
        end else if (cfg_valid) begin
            yaw_rate_reg <= cfg_data;
        end
    end

    logic                 f_valid;
    logic signed [XW-1:0] f_x, f_y;
    logic signed [FRAC_BITS+3:0] f_z;
    side_t                f_side;

    ctsp_front #(
        .ROTATE_STAGES(ROTATE_STAGES),
        .FRAC_BITS    (FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_px    ($signed(s_tdata[31:0])),
        .in_py    ($signed(s_tdata[63:32])),
        .in_vx    ($signed(s_tdata[95:64])),
        .in_vy    ($signed(s_tdata[127:96])),
        .in_dt    (s_tdata[143:128]),
        .yaw_rate (yaw_rate_reg),
        .out_valid(f_valid),
        .out_x    (f_x),
        .out_y    (f_y),
        .out_z    (f_z),
        .out_side (f_side)
    );

    logic                 c_valid;
    logic signed [XW-1:0] c_x, c_y;
    side_t                c_side;

    ctsp_cordic #(
        .ROTATE_STAGES(ROTATE_STAGES),
        .FRAC_BITS    (FRAC_BITS)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (f_valid),
        .in_x     (f_x),
        .in_y     (f_y),
        .in_z     (f_z),
        .in_side  (f_side),
        .out_valid(c_valid),
        .out_x    (c_x),
        .out_y    (c_y),
        .out_side (c_side)
    );

    // rounding stage: drop guard bits, velocity change for the position update
    logic                     rd_valid_reg;
    side_t                    rd_side_reg;
    logic signed [DATA_W-1:0] rd_nvx_reg, rd_nvy_reg;
    logic signed [DV_W-1:0]   rd_dvx_reg, rd_dvy_reg;
    logic signed [RX_W-1:0]   rx_next, ry_next;

    assign rx_next = RX_W'((c_x + XW'(longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS);
    assign ry_next = RX_W'((c_y + XW'(longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (en) begin
            rd_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_side_reg <= c_side;
            rd_nvx_reg  <= sat32(64'(rx_next));
            rd_nvy_reg  <= sat32(64'(ry_next));
            rd_dvx_reg  <= DV_W'(rx_next) - DV_W'(c_side.vx);
            rd_dvy_reg  <= DV_W'(ry_next) - DV_W'(c_side.vy);
        end
    end

    logic signed [Q_W-1:0] qx, qy;

    ctsp_div u_div_x (
        .aclk(aclk),
        .en  (en),
        .num (rd_dvx_reg),
        .den (yaw_rate_reg),
        .quo (qx)
    );

    ctsp_div u_div_y (
        .aclk(aclk),
        .en  (en),
        .num (rd_dvy_reg),
        .den (yaw_rate_reg),
        .quo (qy)
    );

    // delay line that keeps the rest of the word beside the dividers
    logic                     dl_valid_reg [DIV_LAT];
    side_t                    dl_side_reg  [DIV_LAT];
    logic signed [DATA_W-1:0] dl_nvx_reg   [DIV_LAT];
    logic signed [DATA_W-1:0] dl_nvy_reg   [DIV_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                dl_valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            dl_valid_reg[0] <= rd_valid_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                dl_valid_reg[k] <= dl_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_side_reg[0] <= rd_side_reg;
            dl_nvx_reg[0]  <= rd_nvx_reg;
            dl_nvy_reg[0]  <= rd_nvy_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                dl_side_reg[k] <= dl_side_reg[k-1];
                dl_nvx_reg[k]  <= dl_nvx_reg[k-1];
                dl_nvy_reg[k]  <= dl_nvy_reg[k-1];
            end
        end
    end

    // output register
    side_t                    o_side;
    logic signed [DATA_W-1:0] npx_next, npy_next, nvx_next, nvy_next;
    logic [OUT_W-1:0]         m_tdata_next;

    assign o_side = dl_side_reg[DIV_LAT-1];

    always_comb begin
        if (o_side.straight) begin
            npx_next = o_side.lin_px;
            npy_next = o_side.lin_py;
            nvx_next = o_side.vx;
            nvy_next = o_side.vy;
        end else begin
            npx_next = sat32(64'(o_side.px) + 64'(qy));
            npy_next = sat32(64'(o_side.py) - 64'(qx));
            nvx_next = dl_nvx_reg[DIV_LAT-1];
            nvy_next = dl_nvy_reg[DIV_LAT-1];
        end
        m_tdata_next = {nvy_next, nvx_next, npy_next, npx_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dl_valid_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
